@@ rtl/mcts_pkg.sv @@
package mcts_pkg;

  localparam int TICK_W = 64;
  localparam int TIME_W = 61;
  localparam int CHAN_W = 3;
  localparam int DELAY_W = 32;
  localparam int KIND_W = 2;

  localparam int DEF_CHANNELS = 6;
  localparam int DEF_TICKS_PER_US = 12;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET = 2'd2;

  localparam logic [KIND_W-1:0] REPLY_TIME = 2'd0;
  localparam logic [KIND_W-1:0] REPLY_ACK = 2'd1;
  localparam logic [KIND_W-1:0] REPLY_EXPIRY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INC,
    ST_SCAN,
    ST_FLUSH,
    ST_ADD
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

@@ rtl/mcts_ram.sv @@
module mcts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mcts_alu.sv @@
module mcts_alu (
  input  mcts_pkg::alu_op_t               op,
  input  logic [mcts_pkg::TICK_W-1:0]     a,
  input  logic [mcts_pkg::TICK_W-1:0]     b,
  output logic [mcts_pkg::TICK_W-1:0]     res,
  output logic                            carry
);

  logic [mcts_pkg::TICK_W:0] sum;
  logic [mcts_pkg::TICK_W-1:0] b_eff;

  // For a subtraction the carry out is set when a is not below b.
  assign b_eff = (op == mcts_pkg::ALU_SUB) ? ~b : b;
  assign sum = {1'b0, a} + {1'b0, b_eff} + (mcts_pkg::TICK_W + 1)'(op == mcts_pkg::ALU_SUB);
  assign res = sum[mcts_pkg::TICK_W-1:0];
  assign carry = sum[mcts_pkg::TICK_W];

endmodule

@@ rtl/multi_client_timeout_scheduler_unit.sv @@
// Timeout scheduler for several client channels around a 64-bit tick counter.
// A command word is taken when start is high and busy is low; kind selects a
// counter tick, a time query or a set request for one channel.
// Every reply word appears for one cycle with reply_valid high, and last marks
// the final word caused by a command. The receiver cannot stall the block.
// A tick holds busy high while it advances the counter, then reads the
// deadline memory and compares one channel at a time in the shared adder,
// and at last sends the held final expiry notice and steps the microsecond
// count. No new word is taken until a tick is through. A tick that expires
// nothing gives no reply.
// A time query leaves busy low; its reply comes in the cycle after it is
// taken, from a microsecond count that is kept beside the tick counter.
// A set request holds busy high in the add state: the delay is scaled by a
// constant multiplier on acceptance, then added to the counter and written to
// the deadline memory, and the acknowledge comes in the cycle after.
// Unknown commands and set requests for channels that do not exist are
// dropped without a reply. Reset clears the counter, the microsecond count,
// all armed flags and the reply strobe; the deadline memory needs no clearing.
module multi_client_timeout_scheduler_unit #(
  parameter int CHANNELS = mcts_pkg::DEF_CHANNELS,
  parameter int TICKS_PER_US = mcts_pkg::DEF_TICKS_PER_US
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mcts_pkg::KIND_W-1:0]     kind,
  input  logic [mcts_pkg::CHAN_W-1:0]     channel,
  input  logic [mcts_pkg::DELAY_W-1:0]    delay_us,
  output logic                            reply_valid,
  output logic [mcts_pkg::KIND_W-1:0]     reply_kind,
  output logic [mcts_pkg::TIME_W-1:0]     time_us,
  output logic [mcts_pkg::CHAN_W-1:0]     notify_channel,
  output logic                            last
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RW = $clog2(TICKS_PER_US) + 1;
  localparam int PW = mcts_pkg::DELAY_W + $clog2(TICKS_PER_US + 1);
  localparam int TW = mcts_pkg::TICK_W;

  mcts_pkg::state_t state, state_next;

  logic [TW-1:0]                   tick_count, tick_next;
  logic [mcts_pkg::TIME_W-1:0]     us_count, us_next;
  logic [RW-1:0]                   frac, frac_next;
  logic                            us_step, us_step_next;
  logic [CHANNELS-1:0]             armed, armed_next;
  logic                            hold_valid, hold_valid_next;
  logic [CW-1:0]                   hold_chan, hold_chan_next;
  logic [CW-1:0]                   idx, idx_next;
  logic [PW-1:0]                   prod, prod_next;
  logic [mcts_pkg::CHAN_W-1:0]     set_chan, set_chan_next;

  logic                            valid_next;
  logic [mcts_pkg::KIND_W-1:0]     rkind_next;
  logic [mcts_pkg::TIME_W-1:0]     time_next;
  logic [mcts_pkg::CHAN_W-1:0]     nchan_next;
  logic                            last_next;

  mcts_pkg::alu_op_t               alu_op;
  logic [TW-1:0]                   alu_a, alu_b, alu_res;
  logic                            alu_carry;

  logic                            we;
  logic [CW-1:0]                   rd_addr;
  logic [TW-1:0]                   rdata;

  mcts_alu u_alu (
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  mcts_ram #(
    .WIDTH (TW),
    .DEPTH (CHANNELS)
  ) u_deadline (
    .clk   (clk),
    .we    (we),
    .waddr (CW'(set_chan)),
    .wdata (alu_res),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign busy = (state != mcts_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    tick_next = tick_count;
    us_next = us_count;
    frac_next = frac;
    us_step_next = us_step;
    armed_next = armed;
    hold_valid_next = hold_valid;
    hold_chan_next = hold_chan;
    idx_next = idx;
    prod_next = prod;
    set_chan_next = set_chan;
    alu_op = mcts_pkg::ALU_SUB;
    alu_a = tick_count;
    alu_b = rdata;
    rd_addr = idx + CW'(1);
    we = 1'b0;
    valid_next = 1'b0;
    rkind_next = mcts_pkg::REPLY_TIME;
    time_next = '0;
    nchan_next = '0;
    last_next = 1'b0;
    unique case (state)
      mcts_pkg::ST_IDLE: begin
        if (start) begin
          unique case (kind)
            mcts_pkg::KIND_TICK: begin
              state_next = mcts_pkg::ST_INC;
            end
            mcts_pkg::KIND_QUERY: begin
              valid_next = 1'b1;
              rkind_next = mcts_pkg::REPLY_TIME;
              time_next = us_count;
              last_next = 1'b1;
            end
            mcts_pkg::KIND_SET: begin
              if (32'(channel) < CHANNELS) begin
                prod_next = PW'(delay_us) * PW'(TICKS_PER_US);
                set_chan_next = channel;
                state_next = mcts_pkg::ST_ADD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mcts_pkg::ST_INC: begin
        alu_op = mcts_pkg::ALU_ADD;
        alu_b = TW'(1);
        tick_next = alu_res;
        // When the counter wraps to zero the microsecond count restarts too.
        if (alu_carry) begin
          us_next = '0;
          frac_next = '0;
          us_step_next = 1'b0;
        end else if (frac == RW'(TICKS_PER_US - 1)) begin
          frac_next = '0;
          us_step_next = 1'b1;
        end else begin
          frac_next = frac + RW'(1);
          us_step_next = 1'b0;
        end
        idx_next = '0;
        hold_valid_next = 1'b0;
        rd_addr = '0;
        state_next = mcts_pkg::ST_SCAN;
      end
      mcts_pkg::ST_SCAN: begin
        // An expiry is held back one hit so the final one can carry last.
        if (armed[idx] && alu_carry) begin
          armed_next[idx] = 1'b0;
          if (hold_valid) begin
            valid_next = 1'b1;
            rkind_next = mcts_pkg::REPLY_EXPIRY;
            nchan_next = mcts_pkg::CHAN_W'(hold_chan);
          end
          hold_chan_next = idx;
          hold_valid_next = 1'b1;
        end
        if (idx == CW'(CHANNELS - 1)) begin
          state_next = mcts_pkg::ST_FLUSH;
        end else begin
          idx_next = idx + CW'(1);
        end
      end
      mcts_pkg::ST_FLUSH: begin
        alu_op = mcts_pkg::ALU_ADD;
        alu_a = TW'(us_count);
        alu_b = TW'(us_step);
        us_next = alu_res[mcts_pkg::TIME_W-1:0];
        if (hold_valid) begin
          valid_next = 1'b1;
          rkind_next = mcts_pkg::REPLY_EXPIRY;
          nchan_next = mcts_pkg::CHAN_W'(hold_chan);
          last_next = 1'b1;
        end
        hold_valid_next = 1'b0;
        state_next = mcts_pkg::ST_IDLE;
      end
      mcts_pkg::ST_ADD: begin
        alu_op = mcts_pkg::ALU_ADD;
        alu_b = TW'(prod);
        we = 1'b1;
        armed_next[CW'(set_chan)] = 1'b1;
        valid_next = 1'b1;
        rkind_next = mcts_pkg::REPLY_ACK;
        nchan_next = set_chan;
        last_next = 1'b1;
        state_next = mcts_pkg::ST_IDLE;
      end
      default: begin
        state_next = mcts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcts_pkg::ST_IDLE;
      tick_count <= '0;
      us_count <= '0;
      frac <= '0;
      us_step <= 1'b0;
      armed <= '0;
      hold_valid <= 1'b0;
      reply_valid <= 1'b0;
    end else begin
      state <= state_next;
      tick_count <= tick_next;
      us_count <= us_next;
      frac <= frac_next;
      us_step <= us_step_next;
      armed <= armed_next;
      hold_valid <= hold_valid_next;
      reply_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hold_chan <= hold_chan_next;
    idx <= idx_next;
    prod <= prod_next;
    set_chan <= set_chan_next;
    reply_kind <= rkind_next;
    time_us <= time_next;
    notify_channel <= nchan_next;
    last <= last_next;
  end

  a_last_ends_command: assert property (@(posedge clk) disable iff (rst)
    reply_valid && last |-> state == mcts_pkg::ST_IDLE)
    else $error("final reply word while a command is still running");

  a_mid_word_from_scan: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !last |-> state == mcts_pkg::ST_SCAN || state == mcts_pkg::ST_FLUSH)
    else $error("non-final reply word outside a tick scan");

  a_expiry_no_time: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_kind == mcts_pkg::REPLY_EXPIRY |-> time_us == '0)
    else $error("expiry notice carries a time value");

  a_ack_after_add: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply_kind == mcts_pkg::REPLY_ACK |-> $past(state == mcts_pkg::ST_ADD))
    else $error("acknowledge word without a deadline write");

endmodule

@@ dv/timeout_reply_checker.sv @@
module timeout_reply_checker
  import mcts_pkg::*;
#(
  parameter int CHANNELS = DEF_CHANNELS,
  parameter int TICKS_PER_US = DEF_TICKS_PER_US
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [DELAY_W-1:0]  delay_us,
  input  logic                reply_valid,
  input  logic [KIND_W-1:0]   reply_kind,
  input  logic [TIME_W-1:0]   time_us,
  input  logic [CHAN_W-1:0]   notify_channel,
  input  logic                last,
  output int                  errors,
  output int                  outstanding
);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] time_val;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } reply_word_t;

  reply_word_t expected_replies[$];
  reply_word_t oldest;
  logic [TICK_W-1:0] ticks_now;
  logic [TICK_W-1:0] due_at [CHANNELS];
  logic is_armed [CHANNELS];

  initial begin
    errors = 0;
    outstanding = 0;
  end

  function automatic void push_reply(input logic [KIND_W-1:0] k, input logic [TIME_W-1:0] t,
                                     input logic [CHAN_W-1:0] ch, input logic lst);
    reply_word_t w;
    w.kind = k;
    w.time_val = t;
    w.chan = ch;
    w.last = lst;
    expected_replies.push_back(w);
  endfunction

  // Advances the schedule by one command word and queues the replies it causes.
  function automatic void schedule_command(input logic [KIND_W-1:0] k,
                                           input logic [CHAN_W-1:0] ch,
                                           input logic [DELAY_W-1:0] d);
    int expired;
    expired = 0;
    case (k)
      KIND_TICK: begin
        ticks_now = ticks_now + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          if (is_armed[i] && due_at[i] <= ticks_now) begin
            is_armed[i] = 1'b0;
            push_reply(REPLY_EXPIRY, '0, CHAN_W'(i), 1'b0);
            expired++;
          end
        end
        if (expired > 0) begin
          expected_replies[expected_replies.size() - 1].last = 1'b1;
        end
      end
      KIND_QUERY: begin
        push_reply(REPLY_TIME, TIME_W'(ticks_now / TICK_W'(TICKS_PER_US)), '0, 1'b1);
      end
      KIND_SET: begin
        if (ch < CHANNELS) begin
          due_at[ch] = ticks_now + TICK_W'(d) * TICK_W'(TICKS_PER_US);
          is_armed[ch] = 1'b1;
          push_reply(REPLY_ACK, '0, ch, 1'b1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(input string field, input logic [TICK_W-1:0] exp_val,
                                        input logic [TICK_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ticks_now = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        due_at[i] = '0;
        is_armed[i] = 1'b0;
      end
      expected_replies.delete();
    end else begin
      if (start && !busy) begin
        schedule_command(kind, channel, delay_us);
      end
      if (reply_valid) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply word: kind %0d, channel %0d, time %0h",
                 reply_kind, notify_channel, time_us);
          errors++;
        end else begin
          oldest = expected_replies.pop_front();
          compare_field("reply_kind", TICK_W'(oldest.kind), TICK_W'(reply_kind));
          compare_field("time_us", TICK_W'(oldest.time_val), TICK_W'(time_us));
          compare_field("notify_channel", TICK_W'(oldest.chan), TICK_W'(notify_channel));
          compare_field("last", TICK_W'(oldest.last), TICK_W'(last));
        end
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

@@ dv/testbench.sv @@
module testbench;
  import mcts_pkg::*;

  localparam int CHANNELS = DEF_CHANNELS;
  localparam int TICKS_PER_US = DEF_TICKS_PER_US;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] kind = KIND_TICK;
  logic [CHAN_W-1:0] channel = '0;
  logic [DELAY_W-1:0] delay_us = '0;
  logic reply_valid;
  logic [KIND_W-1:0] reply_kind;
  logic [TIME_W-1:0] time_us;
  logic [CHAN_W-1:0] notify_channel;
  logic last;
  int fail_count;
  int waiting;

  always #10 clk = ~clk;

  multi_client_timeout_scheduler_unit #(
    .CHANNELS(CHANNELS),
    .TICKS_PER_US(TICKS_PER_US)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .channel(channel),
    .delay_us(delay_us),
    .reply_valid(reply_valid),
    .reply_kind(reply_kind),
    .time_us(time_us),
    .notify_channel(notify_channel),
    .last(last)
  );

  timeout_reply_checker #(
    .CHANNELS(CHANNELS),
    .TICKS_PER_US(TICKS_PER_US)
  ) checker_inst (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .channel(channel),
    .delay_us(delay_us),
    .reply_valid(reply_valid),
    .reply_kind(reply_kind),
    .time_us(time_us),
    .notify_channel(notify_channel),
    .last(last),
    .errors(fail_count),
    .outstanding(waiting)
  );

  task automatic send_command(input logic [KIND_W-1:0] k, input logic [CHAN_W-1:0] ch,
                              input logic [DELAY_W-1:0] d);
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    channel <= ch;
    delay_us <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic drain_replies();
    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  // Most set requests use short delays so that deadlines actually expire
  // within the run; a few use the full range of the field.
  task automatic send_random_command(output bit useful);
    int pick;
    int shape;
    logic [CHAN_W-1:0] ch;
    logic [DELAY_W-1:0] d;
    pick = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    ch = CHAN_W'($urandom);
    d = $urandom;
    useful = 1'b1;
    if (pick < 55) begin
      send_command(KIND_TICK, ch, d);
    end else if (pick < 80) begin
      if ($urandom_range(0, 9) == 0) begin
        ch = CHAN_W'($urandom_range(CHANNELS, 7));
        useful = 1'b0;
      end else begin
        ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
      end
      if (shape < 70) begin
        d = $urandom_range(0, 4);
      end else if (shape < 85) begin
        d = $urandom_range(5, 40);
      end
      send_command(KIND_SET, ch, d);
    end else if (pick < 94) begin
      send_command(KIND_QUERY, ch, d);
    end else begin
      send_command(KIND_UNUSED, ch, d);
      useful = 1'b0;
    end
  endtask

  initial begin
    int sent;
    int burst_left;
    int guard;
    bit useful;
    bit drained;
    sent = 0;
    burst_left = 0;
    guard = 0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_command(KIND_QUERY, '0, '0);
    for (int i = 0; i < CHANNELS; i++) begin
      send_command(KIND_SET, CHAN_W'(i), '0);
    end
    send_command(KIND_TICK, '1, '1);
    send_command(KIND_SET, 3'd6, 32'd1);
    send_command(KIND_SET, 3'd7, 32'd1);
    send_command(KIND_UNUSED, '1, '1);
    send_command(KIND_SET, 3'd2, 32'hFFFF_FFFF);
    send_command(KIND_SET, 3'd2, 32'd1);
    send_command(KIND_SET, 3'd5, 32'hFFFF_FFFF);
    for (int i = 0; i < TICKS_PER_US; i++) begin
      send_command(KIND_TICK, '0, '0);
    end
    send_command(KIND_QUERY, '1, '1);

    while (sent < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 3) != 0) begin
          hold_off($urandom_range(1, 10));
        end
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        drain_replies();
        drained = 1'b1;
      end
      send_random_command(useful);
      if (useful) begin
        sent++;
      end
      burst_left--;
    end

    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (80) @(negedge clk);
    if (waiting != 0) begin
      $error("%0d expected reply words never arrived", waiting);
    end
    if (fail_count == 0 && waiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
